/* src/svbs_pkg.sv */
`default_nettype none
package svbs_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int MAX_DIM     = 8;
   localparam int VALUE_BITS  = 16;

   localparam int ROW_BITS    = $clog2(MAX_ENTRIES);
   localparam int IDX_BITS    = $clog2(MAX_DIM);
   localparam int ADDR_BITS   = ROW_BITS + IDX_BITS;
   localparam int TABLE_DEPTH = MAX_ENTRIES * MAX_DIM;
   localparam int Q_BITS      = VALUE_BITS + 1;

   localparam int ENTRY_BITS  = 11;
   localparam int POS_BITS    = 3;
   localparam int COUNT_BITS  = 11;
   localparam int LEN_BITS    = 4;
   localparam int CODE_BITS   = 13;
   localparam int SLOT_BITS   = 11;
   localparam int SUM_BITS    = COUNT_BITS + 1;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ENTRY_COUNT   = 2'd0,
      REG_VECTOR_LENGTH = 2'd1
   } reg_index_type;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_READ,
      ST_CMP,
      ST_DONE
   } step_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_INIT,
      OP_MID,
      OP_READ,
      OP_COMPARE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_START,
      COND_EMPTY,
      COND_DIFF,
      COND_MORE,
      COND_BLOCKED
   } cond_code_type;

   typedef struct packed {
      op_type        op;
      cond_code_type cond_a;
      step_type      jump_a;
      cond_code_type cond_b;
      step_type      jump_b;
      step_type      next;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic empty;
      logic diff;
      logic more;
      logic blocked;
   } cond_type;

   // Search program: one control word per step.
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type w;
      w = '{OP_WAIT, COND_NEVER, ST_IDLE, COND_NEVER, ST_IDLE, ST_IDLE};
      unique case (step)
         ST_IDLE:  w = '{OP_WAIT,    COND_NO_START, ST_IDLE,  COND_NEVER, ST_IDLE, ST_SETUP};
         ST_SETUP: w = '{OP_INIT,    COND_NEVER,    ST_IDLE,  COND_NEVER, ST_IDLE, ST_CHECK};
         ST_CHECK: w = '{OP_MID,     COND_EMPTY,    ST_DONE,  COND_NEVER, ST_IDLE, ST_READ};
         ST_READ:  w = '{OP_READ,    COND_NEVER,    ST_IDLE,  COND_NEVER, ST_IDLE, ST_CMP};
         ST_CMP:   w = '{OP_COMPARE, COND_DIFF,     ST_CHECK, COND_MORE,  ST_READ, ST_DONE};
         ST_DONE:  w = '{OP_EMIT,    COND_BLOCKED,  ST_DONE,  COND_NEVER, ST_IDLE, ST_IDLE};
         default:  w = '{OP_WAIT,    COND_NEVER,    ST_IDLE,  COND_NEVER, ST_IDLE, ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic cond_eval(input cond_code_type code, input cond_type c);
      logic r;
      r = 1'b0;
      unique case (code)
         COND_NEVER:    r = 1'b0;
         COND_NO_START: r = !c.start;
         COND_EMPTY:    r = c.empty;
         COND_DIFF:     r = c.diff;
         COND_MORE:     r = c.more;
         COND_BLOCKED:  r = c.blocked;
         default:       r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/svbs_if.sv */
`default_nettype none
interface svbs_req_if import svbs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [ENTRY_BITS-1:0]        entry;
   logic [POS_BITS-1:0]          position;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, kind, entry, position, value, input ready);
   modport sink   (input valid, kind, entry, position, value, output ready);
endinterface

interface svbs_rsp_if import svbs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [CODE_BITS-1:0] result_code;
   logic                        found;
   logic                        negated;
   logic [SLOT_BITS-1:0]        slot;

   modport source (output valid, result_code, found, negated, slot, input ready);
   modport sink   (input valid, result_code, found, negated, slot, output ready);
endinterface

interface svbs_csr_if import svbs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/svbs_ram.sv */
`default_nettype none
module svbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

/* src/svbs_seq.sv */
`default_nettype none
module svbs_seq import svbs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cond_type cond,
   output step_type      step,
   output ctrl_type      ctrl
);

   step_type step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Fetch the control word, then take the first jump whose condition holds.
   always_comb begin
      ctrl = ucode(step_ff);
      if (cond_eval(ctrl.cond_a, cond)) begin
         step_in = ctrl.jump_a;
      end else if (cond_eval(ctrl.cond_b, cond)) begin
         step_in = ctrl.jump_b;
      end else begin
         step_in = ctrl.next;
      end
   end

   assign step = step_ff;

endmodule
`default_nettype wire

/* src/signed_vector_binary_search.sv */
`default_nettype none
// Loads: one element per cycle while the search engine is idle, no result.
// Query: the last element starts a search through setup, then per probe a check and a read
// and compare per element; P probes (at most 11 for 1024 entries), up to E elements compared
// per probe, one table read each on the single read port. The emit step stalls on a pending result.
// Reset clears the sequencer and output valid, sets entry_count to 0 and vector_length to 8;
// table and query storage hold whatever was written and need no clearing pass.
module signed_vector_binary_search import svbs_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   svbs_req_if.sink   req_bus,
   svbs_rsp_if.source rsp_bus,
   svbs_csr_if.sink   csr_bus
);

   // configuration, stored already clamped to the usable range
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;

   logic [VALUE_BITS-1:0] qbuf_ff [MAX_DIM];

   // search datapath
   logic [COUNT_BITS-1:0] low_ff, low_in;
   logic [COUNT_BITS-1:0] high_ff, high_in;
   logic [COUNT_BITS-1:0] mid_ff, mid_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic                  found_ff, found_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [CODE_BITS-1:0] code_ff, code_in;
   logic                        rfound_ff, rfound_in;
   logic                        rneg_ff, rneg_in;
   logic [SLOT_BITS-1:0]        slot_ff, slot_in;

   step_type step;
   ctrl_type ctrl;
   cond_type cond;

   logic                  req_xfer;
   logic                  load_ok;
   logic                  ram_re;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [VALUE_BITS-1:0] ram_rdata;
   logic [IDX_BITS-1:0]   last_pos;
   logic                  neg_calc;
   logic                  seen;
   logic [VALUE_BITS-1:0] qsel;
   logic signed [Q_BITS-1:0] qext, qval, tval;
   logic [SUM_BITS-1:0]   mid_sum;
   logic [SUM_BITS-1:0]   miss_sum;
   logic [SUM_BITS-1:0]   mag;
   logic [CODE_BITS-1:0]  mag_wide;
   logic                  rsp_free;

   // requests are taken only while the sequencer waits; a pending result does not block them
   assign req_bus.ready = (step == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign last_pos      = IDX_BITS'(len_ff - LEN_BITS'(1));

   // ---------------- configuration ----------------
   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_ENTRY_COUNT: begin
               if (csr_bus.data > COUNT_BITS'(MAX_ENTRIES)) begin
                  count_in = COUNT_BITS'(MAX_ENTRIES);
               end else begin
                  count_in = csr_bus.data[COUNT_BITS-1:0];
               end
            end
            REG_VECTOR_LENGTH: begin
               // zero in the low four bits acts as one, 9 to 15 act as full length; higher bits are ignored
               if (csr_bus.data[LEN_BITS-1:0] == '0) begin
                  len_in = LEN_BITS'(1);
               end else if (csr_bus.data[LEN_BITS-1:0] > LEN_BITS'(MAX_DIM)) begin
                  len_in = LEN_BITS'(MAX_DIM);
               end else begin
                  len_in = csr_bus.data[LEN_BITS-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         len_ff   <= LEN_BITS'(MAX_DIM);
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   // ---------------- table store and query buffer ----------------
   // drop loads to entry zero or past the table
   assign load_ok = req_xfer && (req_bus.kind == KIND_LOAD)
                    && (req_bus.entry != '0)
                    && (req_bus.entry <= ENTRY_BITS'(MAX_ENTRIES))
                    && (32'(req_bus.position) < MAX_DIM);

   assign ram_waddr = {ROW_BITS'(req_bus.entry - ENTRY_BITS'(1)),
                       req_bus.position[IDX_BITS-1:0]};
   assign ram_raddr = {ROW_BITS'(mid_ff - COUNT_BITS'(1)), idx_ff};
   assign ram_re    = (ctrl.op == OP_READ);

   svbs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (load_ok),
      .waddr (ram_waddr),
      .wdata (req_bus.value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (req_xfer && (req_bus.kind == KIND_QUERY) && (32'(req_bus.position) < MAX_DIM)) begin
         qbuf_ff[req_bus.position[IDX_BITS-1:0]] <= req_bus.value;
      end
   end

   // the last query element kicks off the search program
   assign cond.start = req_xfer && (req_bus.kind == KIND_QUERY)
                       && (req_bus.position[IDX_BITS-1:0] == last_pos)
                       && (32'(req_bus.position) < MAX_DIM);

   // ---------------- sign of the query ----------------
   // the first nonzero element in use decides whether the whole query flips
   always_comb begin
      neg_calc = 1'b0;
      seen     = 1'b0;
      for (int i = 0; i < MAX_DIM; i++) begin
         if ((i < int'(len_ff)) && !seen && (qbuf_ff[i] != '0)) begin
            seen     = 1'b1;
            neg_calc = qbuf_ff[i][VALUE_BITS-1];
         end
      end
   end

   // ---------------- element compare ----------------
   // one bit of headroom so the most negative value flips exactly
   assign qsel = qbuf_ff[idx_ff];
   assign qext = signed'({qsel[VALUE_BITS-1], qsel});
   assign qval = neg_ff ? -qext : qext;
   assign tval = signed'({ram_rdata[VALUE_BITS-1], ram_rdata});

   assign mid_sum  = SUM_BITS'(low_ff) + SUM_BITS'(high_ff);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign cond.empty   = (low_ff > high_ff);
   assign cond.diff    = (qval != tval);
   assign cond.more    = (idx_ff != last_pos);
   assign cond.blocked = !rsp_free;

   svbs_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .step  (step),
      .ctrl  (ctrl)
   );

   // ---------------- result magnitude ----------------
   // a miss reports count plus the insertion point
   assign miss_sum = SUM_BITS'(count_ff) + SUM_BITS'(low_ff);
   assign mag      = found_ff ? SUM_BITS'(mid_ff) : miss_sum;
   assign mag_wide = CODE_BITS'(mag);

   // ---------------- datapath control ----------------
   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      rfound_in    = rfound_ff;
      rneg_in      = rneg_ff;
      slot_in      = slot_ff;

      // drop the result once its transfer completes
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (ctrl.op)
         OP_WAIT: begin
         end
         OP_INIT: begin
            low_in   = COUNT_BITS'(1);
            high_in  = count_ff;
            neg_in   = neg_calc;
            found_in = 1'b0;
         end
         OP_MID: begin
            mid_in = mid_sum[SUM_BITS-1:1];
            idx_in = '0;
         end
         OP_READ: begin
         end
         OP_COMPARE: begin
            if (qval > tval) begin
               low_in = mid_ff + COUNT_BITS'(1);
            end else if (qval < tval) begin
               high_in = mid_ff - COUNT_BITS'(1);
            end else if (idx_ff == last_pos) begin
               found_in = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               code_in      = neg_ff ? -signed'(mag_wide) : signed'(mag_wide);
               rfound_in    = found_ff;
               rneg_in      = neg_ff;
               slot_in      = found_ff ? mid_ff : low_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      mid_ff    <= mid_in;
      idx_ff    <= idx_in;
      neg_ff    <= neg_in;
      found_ff  <= found_in;
      code_ff   <= code_in;
      rfound_ff <= rfound_in;
      rneg_ff   <= rneg_in;
      slot_ff   <= slot_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_code = code_ff;
   assign rsp_bus.found       = rfound_ff;
   assign rsp_bus.negated     = rneg_ff;
   assign rsp_bus.slot        = slot_ff;

`ifndef SYNTH
   // a new result only appears out of the emit step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step == ST_DONE))
      else $error("result raised outside the emit step");

   // the search window never inverts by more than one
   a_window: assert property (@(posedge clock) disable iff (reset)
      (step == ST_CHECK) |-> (SUM_BITS'(low_ff) <= SUM_BITS'(high_ff) + SUM_BITS'(1)))
      else $error("search bounds crossed");

   // a match names an entry inside the table
   a_found_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rfound_ff) |-> (slot_ff != '0 && slot_ff <= count_ff))
      else $error("match slot outside the table");

   // every table read is followed by its compare
   a_read_cmp: assert property (@(posedge clock) disable iff (reset)
      (step == ST_READ) |=> (step == ST_CMP))
      else $error("table read not followed by compare");
`endif

endmodule
`default_nettype wire
